/* hw/rtl/baa_pkg.sv */
// shared types, constants and codes of the block arena allocator
package baa_pkg;

    localparam int unsigned MAX_BLOCKS_DEF = 16;
    localparam int unsigned PAGE_BYTES_DEF = 4096;

    localparam int unsigned REQ_W    = 16;
    localparam int unsigned PAGES_W  = 16;
    localparam int unsigned GROWTH_W = 8;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned GROWN_W  = PAGES_W + GROWTH_W;

    localparam logic [PAGES_W-1:0]  PAGES_MAX     = '1;
    localparam logic [PAGES_W-1:0]  PAGES_RST     = 16'd1;
    localparam logic [GROWTH_W-1:0] GROWTH_RST    = 8'd2;

    // register indexes
    localparam logic CFG_INITIAL_PAGES = 1'b0;
    localparam logic CFG_GROWTH        = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SIZE = 2'd1,
        ST_FAIL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CARVE_A,
        S_CARVE_B,
        S_TAKE,
        S_WALK,
        S_RELINK,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_CARVE_CALC,
        OP_CARVE_COMMIT,
        OP_TAKE,
        OP_WALK,
        OP_RELINK
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    publish;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic size_big;
        logic head_valid;
        logic can_carve;
        logic fits;
        logic list_empties;
        logic walk_more;
        logic walk_found;
        logic out_free;
    } t_dp_stat;

endpackage

/* hw/rtl/baa_ctrl.sv */
// controller state machine of the block arena allocator
module baa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  baa_pkg::t_dp_stat  i_stat,
    output baa_pkg::t_dp_cmd   o_cmd,
    output logic               o_in_stall
);
    import baa_pkg::*;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_carve_take, n_carve_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_status     <= ST_OK;
            r_carve_take <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_status     <= n_status;
            r_carve_take <= n_carve_take;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_carve_take = r_carve_take;
        o_cmd.op      = OP_NONE;
        o_cmd.publish = 1'b0;
        o_cmd.status  = r_status;
        o_in_stall    = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_stat.size_big) begin
                    n_status = ST_SIZE;
                    n_state  = S_DONE;
                end else if (!i_stat.head_valid) begin
                    if (i_stat.can_carve) begin
                        n_carve_take = 1'b1;
                        n_state      = S_CARVE_A;
                    end else begin
                        n_status = ST_FAIL;
                        n_state  = S_DONE;
                    end
                end else begin
                    o_cmd.op = OP_START;
                    n_state  = S_TAKE;
                end
            end
            S_CARVE_A: begin
                o_cmd.op = OP_CARVE_CALC;
                n_state  = S_CARVE_B;
            end
            S_CARVE_B: begin
                o_cmd.op = OP_CARVE_COMMIT;
                if (r_carve_take) begin
                    n_state = S_TAKE;
                end else begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_TAKE: begin
                o_cmd.op = OP_TAKE;
                if (i_stat.fits) begin
                    n_status = ST_OK;
                    // a filled head leaving an empty list asks for a fresh block
                    if (i_stat.list_empties && i_stat.can_carve) begin
                        n_carve_take = 1'b0;
                        n_state      = S_CARVE_A;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                priority if (i_stat.walk_more) begin
                    o_cmd.op = OP_WALK;
                end else if (i_stat.walk_found) begin
                    n_state = S_RELINK;
                end else if (i_stat.can_carve) begin
                    n_carve_take = 1'b1;
                    n_state      = S_CARVE_A;
                end else begin
                    n_status = ST_FAIL;
                    n_state  = S_DONE;
                end
            end
            S_RELINK: begin
                o_cmd.op = OP_RELINK;
                n_state  = S_TAKE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* hw/rtl/baa_dp.sv */
// datapath of the block arena allocator: block tables, totals, result register
module baa_dp #(
    parameter int unsigned MAX_BLOCKS = baa_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned PAGE_BYTES = baa_pkg::PAGE_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [baa_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic [baa_pkg::REQ_W-1:0]    i_request_bytes,
    input  baa_pkg::t_dp_cmd             i_cmd,
    input  logic                         i_out_stall,
    output baa_pkg::t_dp_stat            o_stat,
    output logic                         o_out_valid,
    output logic [1:0]                   o_status,
    output logic [baa_pkg::ADDR_W-1:0]   o_address,
    output logic [baa_pkg::ADDR_W-1:0]   o_reserved_bytes,
    output logic [baa_pkg::ADDR_W-1:0]   o_unalloc_bytes
);
    import baa_pkg::*;

    localparam int unsigned IW = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned BW = $clog2(64'(65535) * 64'(PAGE_BYTES) + 64'd1);
    localparam logic [IW-1:0] NO_BLOCK = IW'(MAX_BLOCKS);
    localparam logic [BW-1:0] PB       = BW'(PAGE_BYTES);
    localparam logic [REQ_W:0] PB_CMP  = (REQ_W+1)'(PAGE_BYTES);

    logic [ADDR_W-1:0] r_blk_start [MAX_BLOCKS];
    logic [BW-1:0]     r_blk_size  [MAX_BLOCKS];
    logic [BW-1:0]     r_blk_free  [MAX_BLOCKS];
    logic [IW-1:0]     r_blk_next  [MAX_BLOCKS];

    logic [PAGES_W-1:0]  r_initial_pages;
    logic [GROWTH_W-1:0] r_growth;
    logic [IW-1:0]       r_head;
    logic [IW-1:0]       r_count;
    logic [PAGES_W-1:0]  r_pages;
    logic [ADDR_W-1:0]   r_region_end;
    logic [ADDR_W-1:0]   r_total_free;
    logic [REQ_W-1:0]    r_size;
    logic [IW-1:0]       r_ptr;
    logic [IW-1:0]       r_prev;
    logic [IW-1:0]       r_cnt;
    logic [BW-1:0]       r_bytes;
    logic [GROWN_W-1:0]  r_grown;
    logic [ADDR_W-1:0]   r_addr;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [ADDR_W-1:0]   r_out_res;
    logic [ADDR_W-1:0]   r_out_free;

    logic [AW-1:0]     rd_idx;
    logic [AW-1:0]     prev_idx;
    logic [AW-1:0]     cnt_idx;
    logic [ADDR_W-1:0] rd_start;
    logic [BW-1:0]     rd_size;
    logic [BW-1:0]     rd_free;
    logic [IW-1:0]     rd_next;
    logic [BW-1:0]     size_ext;
    logic [BW-1:0]     new_free;
    logic              ptr_valid;
    logic              fits;
    logic [PAGES_W-1:0] pages_sat;
    logic [PAGES_W-1:0] cfg_pages;

    // single read port at the walk pointer
    assign rd_idx    = r_ptr[AW-1:0];
    assign prev_idx  = r_prev[AW-1:0];
    assign cnt_idx   = r_count[AW-1:0];
    assign rd_start  = r_blk_start[rd_idx];
    assign rd_size   = r_blk_size[rd_idx];
    assign rd_free   = r_blk_free[rd_idx];
    assign rd_next   = r_blk_next[rd_idx];
    assign size_ext  = BW'(r_size);
    assign new_free  = rd_free - size_ext;
    assign ptr_valid = (r_ptr < NO_BLOCK);
    assign fits      = ptr_valid && (rd_free >= size_ext);
    assign pages_sat = (r_grown > GROWN_W'(PAGES_MAX)) ? PAGES_MAX : r_grown[PAGES_W-1:0];
    assign cfg_pages = (i_cfg_idx == CFG_INITIAL_PAGES) ? i_cfg_wdata[PAGES_W-1:0]
                                                        : r_initial_pages;

    always_comb begin
        o_stat.size_big     = ({1'b0, r_size} >= PB_CMP);
        o_stat.head_valid   = (r_head < NO_BLOCK);
        o_stat.can_carve    = (r_count < NO_BLOCK) && (r_pages != '0);
        o_stat.fits         = fits;
        o_stat.list_empties = fits && (new_free == '0) && !(rd_next < NO_BLOCK);
        o_stat.walk_more    = ptr_valid && !fits && (r_cnt < NO_BLOCK);
        o_stat.walk_found   = fits;
        o_stat.out_free     = !r_out_valid || !i_out_stall;
    end

    // tables: no reset, every entry is written when its block is carved
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CARVE_COMMIT: begin
                r_blk_start[cnt_idx] <= r_region_end;
                r_blk_size[cnt_idx]  <= r_bytes;
                r_blk_free[cnt_idx]  <= r_bytes;
                r_blk_next[cnt_idx]  <= r_head;
            end
            OP_TAKE: begin
                if (fits) begin
                    r_blk_free[rd_idx] <= new_free;
                    if (new_free == '0) begin
                        r_blk_next[rd_idx] <= NO_BLOCK;
                    end
                end
            end
            OP_RELINK: begin
                r_blk_next[prev_idx] <= rd_next;
                r_blk_next[rd_idx]   <= r_head;
            end
            default: ;
        endcase
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD:       r_size <= i_request_bytes;
            OP_START:      r_ptr  <= r_head;
            OP_CARVE_CALC: begin
                r_bytes <= BW'(r_pages) * PB;
                r_grown <= GROWN_W'(r_pages) * GROWN_W'(r_growth);
            end
            OP_CARVE_COMMIT: r_ptr <= r_count;
            OP_TAKE: begin
                if (fits) begin
                    r_addr <= rd_start + ADDR_W'(rd_size - rd_free);
                end else begin
                    r_prev <= r_ptr;
                    r_ptr  <= rd_next;
                    r_cnt  <= IW'(1);
                end
            end
            OP_WALK: begin
                r_prev <= r_ptr;
                r_ptr  <= rd_next;
                r_cnt  <= r_cnt + IW'(1);
            end
            default: ;
        endcase
    end

    // allocator state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_pages <= PAGES_RST;
            r_growth        <= GROWTH_RST;
            r_head          <= NO_BLOCK;
            r_count         <= '0;
            r_pages         <= PAGES_RST;
            r_region_end    <= '0;
            r_total_free    <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_INITIAL_PAGES) begin
                r_initial_pages <= i_cfg_wdata[PAGES_W-1:0];
            end else begin
                r_growth <= i_cfg_wdata[GROWTH_W-1:0];
            end
            r_head       <= NO_BLOCK;
            r_count      <= '0;
            r_pages      <= cfg_pages;
            r_region_end <= '0;
            r_total_free <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_CARVE_COMMIT: begin
                    r_head       <= r_count;
                    r_count      <= r_count + IW'(1);
                    r_region_end <= r_region_end + ADDR_W'(r_bytes);
                    r_total_free <= r_total_free + ADDR_W'(r_bytes);
                    r_pages      <= pages_sat;
                end
                OP_TAKE: begin
                    if (fits) begin
                        r_total_free <= r_total_free - ADDR_W'(r_size);
                        if (new_free == '0) begin
                            r_head <= rd_next;
                        end
                    end
                end
                OP_RELINK: r_head <= r_ptr;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_status <= i_cmd.status;
            r_out_addr   <= (i_cmd.status == ST_OK) ? r_addr : '0;
            r_out_res    <= r_region_end;
            r_out_free   <= r_total_free;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_address        = r_out_addr;
    assign o_reserved_bytes = r_out_res;
    assign o_unalloc_bytes  = r_out_free;

endmodule

/* hw/rtl/block_arena_allocator.sv */
// top level of the block arena allocator: controller, datapath and ports
// usage
//   input channel: i_in_valid with i_request_bytes, o_in_stall back; a
//   transaction is taken while valid is high and stall is low
//   output channel: o_out_valid with status, address and running totals,
//   i_out_stall back; one result transaction per request
//   config: i_cfg_we, i_cfg_idx, i_cfg_wdata; any write re-initialises the
//   arena (empty block list, totals cleared); the user is to write only
//   while idle, which the block itself does not enforce
//   flow: a size check, then a bump in the head block; a first-fit walk
//   visits up to MAX_BLOCKS blocks, then a relink and a second bump;
//   carving a new block adds a calculate and a commit step
//   one request at a time: o_in_stall is high until the result has been
//   handed to the output register; the walk uses the tables' single read port
//   reset: synchronous, active low; registers back to defaults, list empty
//   stall: the result waits in the output register; the next request is
//   taken meanwhile and holds in its final state until the register frees
module block_arena_allocator #(
    parameter int unsigned MAX_BLOCKS = baa_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned PAGE_BYTES = baa_pkg::PAGE_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [baa_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [baa_pkg::REQ_W-1:0]    i_request_bytes,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic [baa_pkg::ADDR_W-1:0]   o_address,
    output logic [baa_pkg::ADDR_W-1:0]   o_reserved_bytes,
    output logic [baa_pkg::ADDR_W-1:0]   o_unalloc_bytes
);
    import baa_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: size check, head bump, first-fit walk, relink, carve
    baa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // block tables, totals and the result register
    baa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_request_bytes  (i_request_bytes),
        .i_cmd            (cmd),
        .i_out_stall      (i_out_stall),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_address        (o_address),
        .o_reserved_bytes (o_reserved_bytes),
        .o_unalloc_bytes  (o_unalloc_bytes)
    );

endmodule
